FILE: rtl/core/shsp_pkg.sv
package shsp_pkg;

   localparam int Columns   = 1024;
   localparam int Tables    = 2;
   localparam int KeyBits   = 32;
   localparam int ColBits   = $clog2(Columns);
   localparam int TblBits   = (Tables > 1) ? $clog2(Tables) : 1;
   localparam int SlotBits  = $clog2(Tables * Columns);
   localparam int CfgBits   = 11;
   localparam int CountBits = 12;
   localparam logic [CfgBits-1:0] ColumnCountReset = 11'd1021;
   localparam logic [CountBits-1:0] CountMax = 12'd4095;

   localparam logic CmdAdd   = 1'b0;
   localparam logic CmdQuery = 1'b1;

   typedef struct packed {
      logic               command;
      logic [KeyBits-1:0] key;
   } req_type;

   typedef struct packed {
      logic was_present;
      logic stored_new;
      logic table_full;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_WAIT,
      ST_CHECK,
      ST_WRITE,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;
      logic load;
      logic mod_step;
      logic read;
      logic check;
      logic next_slot;
      logic write;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;
      logic zero_key;
      logic mod_done;
      logic hit;
      logic empty;
      logic exhausted;
      logic is_add;
   } stat_type;

endpackage

FILE: rtl/core/shsp_ctrl.sv
module shsp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  shsp_pkg::stat_type  stat,
   output shsp_pkg::cmd_type   cmd,
   output logic                busy
);

   shsp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= shsp_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         shsp_pkg::ST_CLEAR: begin
            if (stat.clear_done) state_in = shsp_pkg::ST_IDLE;
         end
         shsp_pkg::ST_IDLE: begin
            if (start) state_in = shsp_pkg::ST_MOD;
         end
         shsp_pkg::ST_MOD: begin
            if (stat.zero_key) state_in = shsp_pkg::ST_DONE;
            else if (stat.mod_done) state_in = shsp_pkg::ST_READ;
         end
         shsp_pkg::ST_READ:  state_in = shsp_pkg::ST_WAIT;
         shsp_pkg::ST_WAIT:  state_in = shsp_pkg::ST_CHECK;
         shsp_pkg::ST_CHECK: begin
            if (stat.hit) state_in = shsp_pkg::ST_DONE;
            else if (stat.empty) begin
               state_in = stat.is_add ? shsp_pkg::ST_WRITE : shsp_pkg::ST_DONE;
            end else if (stat.exhausted) state_in = shsp_pkg::ST_DONE;
            else state_in = shsp_pkg::ST_READ;
         end
         shsp_pkg::ST_WRITE: state_in = shsp_pkg::ST_DONE;
         shsp_pkg::ST_DONE:  state_in = shsp_pkg::ST_IDLE;
         default:            state_in = shsp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         shsp_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         shsp_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         shsp_pkg::ST_MOD:   cmd.mod_step = 1'b1;
         shsp_pkg::ST_READ:  cmd.read = 1'b1;
         shsp_pkg::ST_WAIT:  ;
         shsp_pkg::ST_CHECK: begin
            cmd.check     = 1'b1;
            cmd.next_slot = !stat.hit && !stat.empty && !stat.exhausted;
         end
         shsp_pkg::ST_WRITE: cmd.write = 1'b1;
         shsp_pkg::ST_DONE:  cmd.finish = 1'b1;
         default:            ;
      endcase
   end

endmodule

FILE: rtl/core/shsp_dpath.sv
module shsp_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  shsp_pkg::req_type                      req_data,
   input  logic                                   csr_valid,
   input  logic [shsp_pkg::CfgBits-1:0]           csr_data,
   input  shsp_pkg::cmd_type                      cmd,
   output shsp_pkg::stat_type                     stat,
   output logic                                   rsp_valid,
   output shsp_pkg::rsp_type                      rsp_data
);

   localparam int CB = shsp_pkg::ColBits;
   localparam int KB = shsp_pkg::KeyBits;

   logic [KB-1:0] mem [shsp_pkg::Tables*shsp_pkg::Columns];
   logic [KB-1:0] rd_ff;

   logic [shsp_pkg::CfgBits-1:0] cfg_ff;
   logic [CB:0]                  cols;
   logic [shsp_pkg::SlotBits-1:0] clr_ff;
   logic [KB-1:0]                key_ff;
   logic                         add_ff;
   logic [KB+CB:0]               rem_ff;   // restoring remainder
   logic [KB-1:0]                quo_ff;   // remaining dividend bits
   logic [$clog2(KB+1)-1:0]      bit_ff;
   logic [CB-1:0]                col_ff;
   logic [shsp_pkg::TblBits-1:0] tbl_ff;
   logic [CB:0]                  visit_ff;
   logic                         zero_set_ff;
   logic [shsp_pkg::CountBits-1:0] count_ff;
   logic                         pres_ff, new_ff, full_ff, rsp_valid_ff;

   logic [shsp_pkg::SlotBits-1:0] addr;
   logic [KB+CB:0]                shifted;
   logic                          last_tbl;

   always_comb begin
      if (cfg_ff == '0) cols = (CB+1)'(1);
      else if ({1'b0, cfg_ff} > (shsp_pkg::CfgBits+1)'(shsp_pkg::Columns))
         cols = (CB+1)'(shsp_pkg::Columns);
      else cols = (CB+1)'(cfg_ff);
   end

   assign addr     = shsp_pkg::SlotBits'(tbl_ff) * shsp_pkg::SlotBits'(shsp_pkg::Columns)
                   + shsp_pkg::SlotBits'(col_ff);
   assign shifted  = {rem_ff[KB+CB-1:0], quo_ff[KB-1]};
   assign last_tbl = (tbl_ff == shsp_pkg::TblBits'(shsp_pkg::Tables - 1));

   assign stat.clear_done = (clr_ff ==
                             shsp_pkg::SlotBits'(shsp_pkg::Tables*shsp_pkg::Columns - 1));
   assign stat.zero_key   = (key_ff == '0);
   assign stat.mod_done   = (bit_ff == '0);
   assign stat.hit        = (rd_ff == key_ff);
   assign stat.empty      = (rd_ff == '0);
   assign stat.exhausted  = last_tbl && (visit_ff == cols);
   assign stat.is_add     = (add_ff == 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= shsp_pkg::ColumnCountReset;
      end else if (csr_valid) begin
         cfg_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) mem[clr_ff] <= '0;
      else if (cmd.write) mem[addr] <= key_ff;
      if (cmd.read) rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step && !stat.clear_done) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_data.key;
         add_ff <= (req_data.command == shsp_pkg::CmdAdd);
         quo_ff <= req_data.key;
         rem_ff <= '0;
         bit_ff <= ($clog2(KB+1))'(KB);
         tbl_ff <= '0;
         visit_ff <= (CB+1)'(1);
      end else if (cmd.mod_step && !stat.mod_done) begin
         quo_ff <= {quo_ff[KB-2:0], 1'b0};
         bit_ff <= bit_ff - 1'b1;
         if (shifted >= (KB+CB+1)'(cols)) rem_ff <= shifted - (KB+CB+1)'(cols);
         else rem_ff <= shifted;
         if (bit_ff == ($clog2(KB+1))'(1)) begin
            if (shifted >= (KB+CB+1)'(cols)) col_ff <= CB'(shifted - (KB+CB+1)'(cols));
            else col_ff <= CB'(shifted);
         end
      end else if (cmd.next_slot) begin
         if (last_tbl) begin
            tbl_ff   <= '0;
            visit_ff <= visit_ff + 1'b1;
            if ((CB+1)'(col_ff) + (CB+1)'(1) >= cols) col_ff <= '0;
            else col_ff <= col_ff + 1'b1;
         end else begin
            tbl_ff <= tbl_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_set_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pres_ff <= 1'b0;
         new_ff  <= 1'b0;
         full_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (cmd.load) begin
            pres_ff <= 1'b0;
            new_ff  <= 1'b0;
            full_ff <= 1'b0;
         end
         if (cmd.mod_step && stat.zero_key) begin
            pres_ff <= zero_set_ff;
            if (add_ff && !zero_set_ff) begin
               zero_set_ff <= 1'b1;
               new_ff      <= 1'b1;
            end
         end
         // check cycle: hit, or add that ran out of slots
         if (cmd.check) begin
            if (stat.hit) pres_ff <= 1'b1;
            else if (!stat.empty && stat.exhausted && add_ff) full_ff <= 1'b1;
         end
         if (cmd.write) begin
            new_ff <= 1'b1;
            if (count_ff != shsp_pkg::CountMax) count_ff <= count_ff + 1'b1;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.was_present = pres_ff;
   assign rsp_data.stored_new  = new_ff;
   assign rsp_data.table_full  = full_ff;

endmodule

FILE: rtl/core/stacked_hash_set_probe.sv
// channel | ports                        | handshake
// request | req_data (command, key)      | start & !busy
// result  | rsp_data (flags)             | rsp_valid, one cycle, no stall
// config  | csr_data (column_count)      | csr_valid & csr_ready
// After reset a clearing pass over every slot (one slot a cycle) holds busy high.
// An item runs a bit-serial remainder (one step per key bit, then a done step),
// then a read, wait and check state per probed slot (registered memory read), a
// write state on a new entry, a done state and a registered result. Zero keys
// go straight to the done state. The receiver cannot stall results.
module stacked_hash_set_probe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  shsp_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output shsp_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [shsp_pkg::CfgBits-1:0]  csr_data
);

   shsp_pkg::cmd_type  cmd;
   shsp_pkg::stat_type stat;

   // config must only be written while idle (the block does not enforce it); always accept
   assign csr_ready = 1'b1;

   shsp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   shsp_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/core/shsp_checker.sv
module shsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input shsp_pkg::rsp_type rsp_data
);

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("start not taken");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_data.was_present, rsp_data.stored_new,
                                rsp_data.table_full}) <= 1) else $error("flags clash");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");

endmodule

bind stacked_hash_set_probe shsp_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
